/* rtl/nnl1_pkg.sv */
package nnl1_pkg;

   // operation codes on req_operation
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_REFERENCE = 1'b1;

   // register index (paddr[2]) on the csr port
   localparam logic REG_VECTOR_LENGTH = 1'b0;

   localparam int VALUE_W    = 32;
   localparam int MAG_W      = VALUE_W + 1;
   localparam int DIST_W     = 40;
   localparam int INDEX_W    = 10;
   localparam int ELEM_IDX_W = 5;
   localparam int LEN_W      = 6;
   localparam int LEN_LIMIT  = 32;

   localparam logic [LEN_W-1:0]  VLEN_RESET = 6'd19;
   localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

   // one reference element handed from front to back
   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             closing;
      logic             last;
   } entry_type;

endpackage

/* rtl/nnl1_front.sv */
module nnl1_front #(
   parameter int VECTOR_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [nnl1_pkg::LEN_W-1:0]          vector_length,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [nnl1_pkg::ELEM_IDX_W-1:0]     req_element_index,
   input  logic signed [nnl1_pkg::VALUE_W-1:0] req_element_value,
   input  logic                                req_last_reference,
   output logic                                push,
   output nnl1_pkg::entry_type                 push_entry,
   input  logic                                fifo_full
);

   localparam int AW      = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam int LEN_CAP = (VECTOR_DEPTH < nnl1_pkg::LEN_LIMIT) ?
                            VECTOR_DEPTH : nnl1_pkg::LEN_LIMIT;

   logic [nnl1_pkg::VALUE_W-1:0] query_mem [VECTOR_DEPTH];

   logic                         s1_valid_ff, s1_valid_in;
   logic [nnl1_pkg::VALUE_W-1:0] s1_value_ff;
   logic [nnl1_pkg::VALUE_W-1:0] s1_query_ff;
   logic                         s1_closing_ff;
   logic                         s1_last_ff;

   logic                         accept;
   logic [nnl1_pkg::LEN_W-1:0]   eff_len;
   logic [nnl1_pkg::LEN_W-1:0]   idx_ext;
   logic                         in_range;
   logic                         is_ref;
   logic                         load_ok;
   logic [AW-1:0]                addr;
   logic [nnl1_pkg::MAG_W-1:0]   diff;

   // effective vector length, clamped to 1..min(32, depth)
   always_comb begin
      eff_len = vector_length;
      if (vector_length == '0) begin
         eff_len = nnl1_pkg::LEN_W'(1);
      end else if (vector_length > nnl1_pkg::LEN_W'(LEN_CAP)) begin
         eff_len = nnl1_pkg::LEN_W'(LEN_CAP);
      end
   end

   // classify the incoming item
   assign idx_ext  = nnl1_pkg::LEN_W'(req_element_index);
   assign in_range = idx_ext < eff_len;
   assign is_ref   = (req_operation == nnl1_pkg::OP_REFERENCE) && in_range;
   assign load_ok  = (req_operation == nnl1_pkg::OP_LOAD) &&
                     (32'(req_element_index) < VECTOR_DEPTH);
   assign addr     = AW'(req_element_index);

   assign req_stall = s1_valid_ff && fifo_full;
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && !fifo_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = is_ref;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // query store: write on loads, registered read on references
   always_ff @(posedge clock) begin
      if (accept && load_ok) begin
         query_mem[addr] <= req_element_value;
      end
      if (accept && is_ref) begin
         s1_query_ff   <= query_mem[addr];
         s1_value_ff   <= req_element_value;
         s1_closing_ff <= idx_ext == (eff_len - nnl1_pkg::LEN_W'(1));
         s1_last_ff    <= req_last_reference;
      end
   end

   // absolute difference, exact in 33 bits
   assign diff = {s1_value_ff[nnl1_pkg::VALUE_W-1], s1_value_ff} -
                 {s1_query_ff[nnl1_pkg::VALUE_W-1], s1_query_ff};

   always_comb begin
      push_entry.mag     = diff[nnl1_pkg::MAG_W-1] ? (~diff + nnl1_pkg::MAG_W'(1)) : diff;
      push_entry.closing = s1_closing_ff;
      push_entry.last    = s1_last_ff;
   end

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fifo_full) |=> (s1_valid_ff && $stable(s1_value_ff)))
      else $error("front stage lost a held element");

endmodule

/* rtl/nnl1_fifo.sv */
module nnl1_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nnl1_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output nnl1_pkg::entry_type head
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   nnl1_pkg::entry_type   slots [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]           count_ff, count_in;

   assign full      = count_ff == (PW+1)'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slots[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !not_empty))
      else $error("queue overflow or underflow");

endmodule

/* rtl/nnl1_back.sv */
module nnl1_back #(
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              not_empty,
   input  nnl1_pkg::entry_type               head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nnl1_pkg::INDEX_W-1:0]      rsp_nearest_index,
   output logic [nnl1_pkg::DIST_W-1:0]       rsp_nearest_distance
);

   localparam int CW = $clog2(MAX_CANDIDATES);

   logic [nnl1_pkg::DIST_W-1:0]  running_ff, running_in;
   logic [nnl1_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [CW-1:0]                best_idx_ff, best_idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         have_best_ff, have_best_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nnl1_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [nnl1_pkg::DIST_W-1:0]  rsp_dist_ff;

   logic                         out_free;
   logic                         emit;
   logic [nnl1_pkg::DIST_W:0]    sum_wide;
   logic [nnl1_pkg::DIST_W-1:0]  sum;

   // an entry that produces a result waits for a free output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = not_empty && (!(head.closing && head.last) || out_free);
   assign emit     = pop && head.closing && head.last;

   // saturating accumulate
   assign sum_wide = {1'b0, running_ff} + (nnl1_pkg::DIST_W+1)'(head.mag);
   assign sum      = sum_wide[nnl1_pkg::DIST_W] ? nnl1_pkg::DIST_MAX :
                     sum_wide[nnl1_pkg::DIST_W-1:0];

   always_comb begin
      running_in   = running_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      count_in     = count_ff;
      have_best_in = have_best_ff;
      if (pop) begin
         running_in = sum;
         if (head.closing) begin
            if (!have_best_ff || sum < best_dist_ff) begin
               best_dist_in = sum;
               best_idx_in  = count_ff;
               have_best_in = 1'b1;
            end
            if (count_ff < CW'(MAX_CANDIDATES - 1)) begin
               count_in = count_ff + CW'(1);
            end
            running_in = '0;
         end
      end
      if (emit) begin
         running_in   = '0;
         best_dist_in = '0;
         best_idx_in  = '0;
         count_in     = '0;
         have_best_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         best_dist_ff <= '0;
         best_idx_ff  <= '0;
         count_ff     <= '0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         count_ff     <= count_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload; winner of the closing vector recomputed from sum and the current best
   always_ff @(posedge clock) begin
      if (emit) begin
         if (!have_best_ff || sum < best_dist_ff) begin
            rsp_index_ff <= nnl1_pkg::INDEX_W'(count_ff);
            rsp_dist_ff  <= sum;
         end else begin
            rsp_index_ff <= nnl1_pkg::INDEX_W'(best_idx_ff);
            rsp_dist_ff  <= best_dist_ff;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_nearest_index    = rsp_index_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (!have_best_ff && count_ff == '0 && running_ff == '0))
      else $error("search state not cleared after result");

   a_count_needs_best: assert property (@(posedge clock) disable iff (reset)
      !have_best_ff |-> (count_ff == '0))
      else $error("vector count advanced without a best");

endmodule

/* rtl/nearest_neighbour_l1_search.sv */
// The result appears on rsp_valid once the closing element of the final reference
// vector is transferred and has passed the front register, the queue and the result register.
// Throughput: one element per cycle while req_stall is low, loads and references alike; the single
// saturating 40-bit accumulate in the back part sets the rate.
// Reset (synchronous, active high) clears search state, queue and handshakes
// and sets vector_length to 19; the query store is not cleared.
module nearest_neighbour_l1_search #(
   parameter int VECTOR_DEPTH   = 32,
   parameter int MAX_CANDIDATES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // csr port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [nnl1_pkg::ELEM_IDX_W-1:0]     req_element_index,
   input  logic signed [nnl1_pkg::VALUE_W-1:0] req_element_value,
   input  logic                                req_last_reference,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nnl1_pkg::INDEX_W-1:0]        rsp_nearest_index,
   output logic [nnl1_pkg::DIST_W-1:0]         rsp_nearest_distance
);

   logic [nnl1_pkg::LEN_W-1:0] vlen_ff;
   logic                       csr_write;
   logic                       push, pop, fifo_full, not_empty;
   nnl1_pkg::entry_type        push_entry, head;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == nnl1_pkg::REG_VECTOR_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= nnl1_pkg::VLEN_RESET;
      end else if (csr_write) begin
         vlen_ff <= csr_pwdata[nnl1_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == nnl1_pkg::REG_VECTOR_LENGTH) begin
         csr_prdata = 32'(vlen_ff);
      end
   end

   nnl1_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .vector_length      (vlen_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_element_index  (req_element_index),
      .req_element_value  (req_element_value),
      .req_last_reference (req_last_reference),
      .push               (push),
      .push_entry         (push_entry),
      .fifo_full          (fifo_full)
   );

   nnl1_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   nnl1_back #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .not_empty            (not_empty),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_nearest_index    (rsp_nearest_index),
      .rsp_nearest_distance (rsp_nearest_distance)
   );

endmodule

/* verif/nearest_neighbour_l1_search_tb.sv */
module nearest_neighbour_l1_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VECTOR_DEPTH   = 32;
   localparam int MAX_CANDIDATES = 1024;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PHASE_ITEMS    = 95;
   localparam int PHASE_COUNT    = 7;
   localparam logic [2:0] VLEN_ADDR = {nnl1_pkg::REG_VECTOR_LENGTH, 2'b00};

   typedef struct packed {
      logic [nnl1_pkg::INDEX_W-1:0] vec_index;
      logic [nnl1_pkg::DIST_W-1:0]  distance;
   } nearest_type;

   typedef struct packed {
      logic                            op;
      logic [nnl1_pkg::ELEM_IDX_W-1:0] idx;
      logic [nnl1_pkg::VALUE_W-1:0]    val;
      logic                            last;
      bit                              known;
      nearest_type                     result;
   } stim_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // csr port
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // element and result channels
   logic                                req_valid          = 1'b0;
   logic                                req_stall;
   logic                                req_operation      = nnl1_pkg::OP_LOAD;
   logic [nnl1_pkg::ELEM_IDX_W-1:0]     req_element_index  = '0;
   logic signed [nnl1_pkg::VALUE_W-1:0] req_element_value  = '0;
   logic                                req_last_reference = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall          = 1'b0;
   logic [nnl1_pkg::INDEX_W-1:0]        rsp_nearest_index;
   logic [nnl1_pkg::DIST_W-1:0]         rsp_nearest_distance;

   // search model state
   logic [nnl1_pkg::VALUE_W-1:0] query_mem [VECTOR_DEPTH];
   logic [nnl1_pkg::LEN_W-1:0]   vlen       = nnl1_pkg::VLEN_RESET;
   logic [nnl1_pkg::DIST_W-1:0]  dist_sum   = '0;
   logic [nnl1_pkg::DIST_W-1:0]  best_dist  = '0;
   logic [nnl1_pkg::INDEX_W-1:0] best_idx   = '0;
   logic [nnl1_pkg::INDEX_W-1:0] vec_count  = '0;
   bit                           have_best  = 1'b0;

   nearest_type nearest_q [$];
   int unsigned mismatches   = 0;
   int unsigned useful_items = 0;
   int unsigned cycle_count  = 0;

   // sender and receiver pacing
   int unsigned gap_max    = 3;
   int unsigned burst_left = 0;
   logic [3:0]  hold_ticket = '0;
   logic [3:0]  hold_served = '0;
   int unsigned hold_left   = 0;
   int unsigned mode_left   = 0;
   int unsigned stall_pct   = 0;

   logic [nnl1_pkg::VALUE_W-1:0] prev_vals [VECTOR_DEPTH];

   // directed rows, run with vector_length 2
   stim_row_type directed_rows [0:20] = '{
      '{nnl1_pkg::OP_LOAD,      5'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_LOAD,      5'd1,  32'h8000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      // extremes in both elements
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h8000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h7FFF_FFFF, 1'b1, 1'b1,
        '{10'd0, 40'h01_FFFF_FFFE}},
      // index past the length is dropped, last flag with it
      '{nnl1_pkg::OP_REFERENCE, 5'd2,  32'h0000_0000, 1'b1, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b0, '{10'd0, 40'd0}},
      // closing element alone, then last flag on a non-closing element; tie
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0000, 1'b1, 1'b1, '{10'd0, 40'd0}},
      // load mid-search leaves the search state alone
      '{nnl1_pkg::OP_LOAD,      5'd31, 32'h1234_5678, 1'b1, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h0000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_LOAD,      5'd0,  32'h0000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'hFFFF_FFFF, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h0000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0000, 1'b1, 1'b1, '{10'd1, 40'd0}},
      // fractional values, third vector wins
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h0001_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'hFFFF_0000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0001, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd0,  32'h0000_8000, 1'b0, 1'b0, '{10'd0, 40'd0}},
      '{nnl1_pkg::OP_REFERENCE, 5'd1,  32'h8000_0000, 1'b1, 1'b1,
        '{10'd2, 40'h00_0000_8000}}
   };

   logic [nnl1_pkg::LEN_W-1:0] phase_len [PHASE_COUNT] =
      '{6'd32, 6'd0, 6'd19, 6'd63, 6'd1, 6'd7, 6'd3};

   nearest_neighbour_l1_search #(
      .VECTOR_DEPTH  (VECTOR_DEPTH),
      .MAX_CANDIDATES(MAX_CANDIDATES)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_element_index   (req_element_index),
      .req_element_value   (req_element_value),
      .req_last_reference  (req_last_reference),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_nearest_distance(rsp_nearest_distance)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // elements in use per vector after clamping
   function automatic int unsigned active_length();
      int unsigned n;
      n = vlen;
      if (n == 0) n = 1;
      if (n > nnl1_pkg::LEN_LIMIT) n = nnl1_pkg::LEN_LIMIT;
      if (n > VECTOR_DEPTH) n = VECTOR_DEPTH;
      return n;
   endfunction

   // one element through the L1 search; returns 1 when a nearest result is due
   function automatic bit l1_search_step(input logic op,
                                         input logic [nnl1_pkg::ELEM_IDX_W-1:0] idx,
                                         input logic [nnl1_pkg::VALUE_W-1:0] val,
                                         input logic last,
                                         output nearest_type found);
      int unsigned n;
      longint      diff;
      logic [nnl1_pkg::DIST_W:0] total;
      found = '0;
      if (op == nnl1_pkg::OP_LOAD) begin
         query_mem[idx] = val;
         return 1'b0;
      end
      n = active_length();
      if (idx >= n) return 1'b0;
      diff = longint'($signed(val)) - longint'($signed(query_mem[idx]));
      if (diff < 0) diff = -diff;
      total = {1'b0, dist_sum} + diff[nnl1_pkg::DIST_W:0];
      dist_sum = total[nnl1_pkg::DIST_W] ? nnl1_pkg::DIST_MAX :
                 total[nnl1_pkg::DIST_W-1:0];
      if (idx != n - 1) return 1'b0;
      // vector closed: strictly smaller replaces, so the earliest wins ties
      if (!have_best || dist_sum < best_dist) begin
         best_dist = dist_sum;
         best_idx  = vec_count;
         have_best = 1'b1;
      end
      if (vec_count < MAX_CANDIDATES - 1) vec_count++;
      dist_sum = '0;
      if (!last) return 1'b0;
      found.vec_index = best_idx;
      found.distance  = best_dist;
      best_dist = '0;
      best_idx  = '0;
      vec_count = '0;
      have_best = 1'b0;
      return 1'b1;
   endfunction

   // extremes, exact matches and near misses mixed with plain random
   function automatic logic [nnl1_pkg::VALUE_W-1:0] feature_value(
         input logic [nnl1_pkg::VALUE_W-1:0] q);
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return q;
         4: return q + 32'($urandom_range(511)) - 32'd256;
         default: return 32'($urandom);
      endcase
   endfunction

   // one transfer on the element channel, sender bursts and gaps included
   task automatic send_element(input logic op,
                               input logic [nnl1_pkg::ELEM_IDX_W-1:0] idx,
                               input logic [nnl1_pkg::VALUE_W-1:0] val,
                               input logic last,
                               input bit use_fixed = 1'b0,
                               input nearest_type fixed_result = '0);
      nearest_type predicted;
      bit          produced;
      if (gap_max != 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0) burst_left--;
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_element_index  <= idx;
      req_element_value  <= val;
      req_last_reference <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == nnl1_pkg::OP_LOAD || idx < active_length()) useful_items++;
      produced = l1_search_step(op, idx, val, last, predicted);
      if (use_fixed) nearest_q = {nearest_q, fixed_result};
      else if (produced) nearest_q = {nearest_q, predicted};
   endtask

   // block idle: every result in and the pipeline flushed
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vector_length(input logic [nnl1_pkg::LEN_W-1:0] len_val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= VLEN_ADDR;
      csr_pwdata  <= 32'(len_val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      vlen = len_val;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[nnl1_pkg::LEN_W-1:0] !== len_val) begin
         $error("vector_length: expected %0d, got %0d", len_val,
                csr_prdata[nnl1_pkg::LEN_W-1:0]);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // occasional dropped element or query reload between elements
   task automatic send_noise(input int unsigned n);
      if ($urandom_range(11) == 0) begin
         if (n < VECTOR_DEPTH && $urandom_range(1) == 1)
            send_element(nnl1_pkg::OP_REFERENCE,
                         5'($urandom_range(VECTOR_DEPTH - 1, n)),
                         32'($urandom), 1'($urandom_range(1)));
         else
            send_element(nnl1_pkg::OP_LOAD, 5'($urandom_range(VECTOR_DEPTH - 1)),
                         feature_value(32'($urandom)), 1'($urandom_range(1)));
      end
   endtask

   // one search: a few reference vectors, the final one flagged
   task automatic run_search();
      int unsigned        n;
      int unsigned        nvec;
      int                 j;
      logic [4:0]         tmp;
      logic [4:0]         order [VECTOR_DEPTH];
      bit                 copy_prev;
      bit                 broken;
      n = active_length();
      nvec = (n <= 4) ? $urandom_range(1, 12) : $urandom_range(1, 4);
      for (int v = 0; v < nvec; v++) begin
         for (int e = 0; e < n; e++) order[e] = 5'(e);
         // any order before the closing element
         if ($urandom_range(3) == 0) begin
            for (int e = n - 2; e > 0; e--) begin
               j = $urandom_range(e);
               tmp = order[e];
               order[e] = order[j];
               order[j] = tmp;
            end
         end
         copy_prev = (v > 0) && ($urandom_range(5) == 0);
         broken = ($urandom_range(11) == 0);
         for (int e = 0; e < n; e++) begin
            int k;
            k = order[e];
            // values are kept for skipped elements too, so a copy is complete
            if (!copy_prev) prev_vals[k] = feature_value(query_mem[k]);
            if (broken && e != n - 1 && $urandom_range(2) == 0) continue;
            send_noise(n);
            send_element(nnl1_pkg::OP_REFERENCE, 5'(k), prev_vals[k],
                         (e == n - 1) ? (v == nvec - 1) : ($urandom_range(4) == 0));
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin : result_check
      nearest_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (nearest_q.size() == 0) begin
            $error("unexpected result: index %0d distance %0h",
                   rsp_nearest_index, rsp_nearest_distance);
            mismatches++;
         end else begin
            want = nearest_q.pop_front();
            if (rsp_nearest_index !== want.vec_index) begin
               $error("nearest_index: expected %0d, got %0d",
                      want.vec_index, rsp_nearest_index);
               mismatches++;
            end
            if (rsp_nearest_distance !== want.distance) begin
               $error("nearest_distance: expected %0h, got %0h",
                      want.distance, rsp_nearest_distance);
               mismatches++;
            end
         end
      end
   end

   // receiver: random stall modes, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_pct <= $urandom_range(3) * 28;
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int unsigned phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      write_vector_length(6'd2);
      foreach (directed_rows[i])
         send_element(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].last, directed_rows[i].known,
                      directed_rows[i].result);
      wait_idle();

      // random phases, one vector_length each; query reloaded at the start
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_vector_length(phase_len[p]);
         phase_start = useful_items;
         gap_max = (p == 2) ? 0 : ((p % 2 == 1) ? 8 : 3);
         if (p == 1 || p == 4) hold_ticket <= hold_ticket + 1'b1;
         for (int i = 0; i < VECTOR_DEPTH; i++)
            send_element(nnl1_pkg::OP_LOAD, 5'(i), feature_value(32'($urandom)),
                         1'($urandom_range(1)));
         while (useful_items - phase_start < PHASE_ITEMS) run_search();
         wait_idle();
      end

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
